// ===== hdl/mbjd_pkg.sv =====
// Package for the memory-budget job dispatcher: widths, codes, state type.
// No dependencies.
package mbjd_pkg;
  localparam int unsigned MaxJobsDefault = 256;
  localparam int unsigned MemW  = 48;
  localparam int unsigned TimeW = 32;
  localparam int unsigned IdxW  = 8;
  localparam int unsigned EntW  = TimeW + MemW + IdxW;

  typedef enum logic [1:0] {
    FUNC_LOAD     = 2'd0,
    FUNC_DISPATCH = 2'd1,
    FUNC_RELEASE  = 2'd2,
    FUNC_NONE     = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_LOADED    = 3'd0,
    ST_FULL      = 3'd1,
    ST_DISPATCH  = 3'd2,
    ST_WAIT      = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_RELEASED  = 3'd5,
    ST_UNDERFLOW = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_LSCAN_RD,
    S_LSCAN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_LPUT,
    S_FSCAN_RD,
    S_FSCAN,
    S_REM_RD,
    S_REM_WR,
    S_OUT
  } state_t;
endpackage

// ===== hdl/memory_budget_job_dispatcher.sv =====
// Top level of the memory-budget job dispatcher: sequencer, counters, result
// register. Depends on mbjd_pkg and mbjd_table.
// Usage
//   Input channel (in_valid/in_ready) carries func, run_time, mem_amount.
//   Output channel (out_valid/out_ready) carries status, job_index, job_mem,
//   memory_in_use; one beat per item with func 0..2, none for 3.
//   Config channel (cfg_valid/cfg_ready) writes memory_budget; write only
//   while idle.
// Sequencing
//   One item at a time; the table memory has one read and one write port with
//   registered read data. A load scans for its slot (a read and a compare per
//   entry examined) and shifts the tail up (a read and a write per entry
//   moved); into an empty table it writes at once. A dispatch scans for a
//   fitting job and closes the gap, or reports a wait when nothing fits.
//   Release, full table and empty go straight to output; func 3 to idle.
// Reset
//   Synchronous rst empties the table (count 0), clears index counter, usage
//   and budget. Table contents are never cleared; only entries below the
//   count are read.
// Stall
//   A waiting beat sits in the result register; the next item is accepted and
//   worked, then the sequencer holds in its output state until the beat goes.
module memory_budget_job_dispatcher #(
  parameter int unsigned MAX_JOBS = mbjd_pkg::MaxJobsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] run_time,
  input  logic [47:0] mem_amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  job_index,
  output logic [47:0] job_mem,
  output logic [47:0] memory_in_use,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [47:0] memory_budget
);
  localparam int unsigned AW = $clog2(MAX_JOBS);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned TW = mbjd_pkg::TimeW;
  localparam int unsigned MW = mbjd_pkg::MemW;
  localparam int unsigned IW = mbjd_pkg::IdxW;
  localparam int unsigned EW = mbjd_pkg::EntW;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_JOBS);

  mbjd_pkg::state_t state, state_next;

  // item registers
  logic [1:0]     req_func;
  logic [TW-1:0]  req_time;
  logic [MW-1:0]  req_mem;
  // working result, copied to the outputs when the result register frees
  mbjd_pkg::status_t res_status;
  logic [IW-1:0]  res_index;
  logic [MW-1:0]  res_mem;
  // bookkeeping
  logic [CW-1:0]  count;
  logic [8:0]     next_idx;
  logic [MW-1:0]  usage;
  logic [MW-1:0]  budget;
  logic [CW-1:0]  pos;
  logic [CW-1:0]  ptr;
  // memory port
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [EW-1:0]  wdata, rdata;
  logic [TW-1:0]  rd_time;
  logic [MW-1:0]  rd_mem;
  logic [IW-1:0]  rd_idx;
  logic [MW:0]    fit_sum;
  logic           fits;

  assign rd_time = rdata[EW-1 -: TW];
  assign rd_mem  = rdata[IW +: MW];
  assign rd_idx  = rdata[IW-1:0];
  assign fit_sum = {1'b0, rd_mem} + {1'b0, usage};
  assign fits    = fit_sum <= {1'b0, budget};

  mbjd_table #(.MAX_JOBS(MAX_JOBS), .AW(AW)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign in_ready  = (state == mbjd_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mbjd_pkg::S_IDLE:
        if (in_valid) state_next = mbjd_pkg::S_DECIDE;
      mbjd_pkg::S_DECIDE: begin
        unique case (req_func)
          mbjd_pkg::FUNC_LOAD:
            state_next = (count >= MaxCount) ? mbjd_pkg::S_OUT
                       : (count == '0) ? mbjd_pkg::S_LPUT : mbjd_pkg::S_LSCAN_RD;
          mbjd_pkg::FUNC_DISPATCH:
            state_next = (count == '0) ? mbjd_pkg::S_OUT : mbjd_pkg::S_FSCAN_RD;
          mbjd_pkg::FUNC_RELEASE: state_next = mbjd_pkg::S_OUT;
          default: state_next = mbjd_pkg::S_IDLE;
        endcase
      end
      mbjd_pkg::S_LSCAN_RD: state_next = mbjd_pkg::S_LSCAN;
      mbjd_pkg::S_LSCAN:
        if (rd_time < req_time || pos + 1'b1 == count) begin
          state_next = mbjd_pkg::S_SHIFT_RD;
        end else begin
          state_next = mbjd_pkg::S_LSCAN_RD;
        end
      mbjd_pkg::S_SHIFT_RD:
        state_next = (ptr == pos) ? mbjd_pkg::S_LPUT : mbjd_pkg::S_SHIFT_WR;
      mbjd_pkg::S_SHIFT_WR: state_next = mbjd_pkg::S_SHIFT_RD;
      mbjd_pkg::S_LPUT: state_next = mbjd_pkg::S_OUT;
      mbjd_pkg::S_FSCAN_RD: state_next = mbjd_pkg::S_FSCAN;
      mbjd_pkg::S_FSCAN:
        if (usage == '0 || fits) begin
          state_next = mbjd_pkg::S_REM_RD;
        end else if (pos + 1'b1 == count) begin
          state_next = mbjd_pkg::S_OUT;
        end else begin
          state_next = mbjd_pkg::S_FSCAN_RD;
        end
      mbjd_pkg::S_REM_RD:
        state_next = (ptr + 1'b1 >= count) ? mbjd_pkg::S_OUT : mbjd_pkg::S_REM_WR;
      mbjd_pkg::S_REM_WR: state_next = mbjd_pkg::S_REM_RD;
      mbjd_pkg::S_OUT:
        if (!out_valid || out_ready) state_next = mbjd_pkg::S_IDLE;
      default: state_next = mbjd_pkg::S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = ptr[AW-1:0];
    wdata = rdata;
    raddr = pos[AW-1:0];
    unique case (state)
      mbjd_pkg::S_SHIFT_RD: raddr = AW'(ptr - 1'b1);
      mbjd_pkg::S_SHIFT_WR: we = 1'b1;
      mbjd_pkg::S_LPUT: begin
        we    = 1'b1;
        waddr = pos[AW-1:0];
        wdata = {req_time, req_mem, next_idx[IW-1:0]};
      end
      mbjd_pkg::S_REM_RD: raddr = AW'(ptr + 1'b1);
      mbjd_pkg::S_REM_WR: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mbjd_pkg::S_IDLE;
      count     <= '0;
      next_idx  <= '0;
      usage     <= '0;
      budget    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) budget <= memory_budget;
      // load a new beat when the register is free or its beat leaves now
      if (state == mbjd_pkg::S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        mbjd_pkg::S_IDLE:
          if (in_valid) begin
            req_func <= func;
            req_time <= run_time;
            req_mem  <= mem_amount;
            pos      <= '0;
          end
        mbjd_pkg::S_DECIDE: begin
          res_status <= mbjd_pkg::ST_LOADED;
          res_index  <= '0;
          res_mem    <= '0;
          ptr        <= count;
          unique case (req_func)
            mbjd_pkg::FUNC_LOAD:
              if (count >= MaxCount) res_status <= mbjd_pkg::ST_FULL;
            mbjd_pkg::FUNC_DISPATCH: res_status <= mbjd_pkg::ST_EMPTY;
            mbjd_pkg::FUNC_RELEASE:
              if (req_mem > usage) begin
                usage      <= '0;
                res_status <= mbjd_pkg::ST_UNDERFLOW;
              end else begin
                usage      <= usage - req_mem;
                res_status <= mbjd_pkg::ST_RELEASED;
              end
            default: ;
          endcase
        end
        mbjd_pkg::S_LSCAN:
          // stop at first shorter job; past the tail when none is shorter
          if (!(rd_time < req_time)) pos <= pos + 1'b1;
        mbjd_pkg::S_SHIFT_WR: ptr <= ptr - 1'b1;
        mbjd_pkg::S_LPUT: begin
          count     <= count + 1'b1;
          res_index <= next_idx[IW-1:0];
          next_idx  <= next_idx + 1'b1;
        end
        mbjd_pkg::S_FSCAN:
          if (usage == '0 || fits) begin
            res_status <= mbjd_pkg::ST_DISPATCH;
            res_index  <= rd_idx;
            res_mem    <= rd_mem;
            usage      <= fit_sum[MW-1:0];
            ptr        <= pos;
          end else begin
            res_status <= mbjd_pkg::ST_WAIT;
            pos        <= pos + 1'b1;
          end
        mbjd_pkg::S_REM_RD:
          if (ptr + 1'b1 >= count) count <= count - 1'b1;
        mbjd_pkg::S_REM_WR: ptr <= ptr + 1'b1;
        mbjd_pkg::S_OUT:
          if (!out_valid || out_ready) begin
            status        <= res_status;
            job_index     <= res_index;
            job_mem       <= res_mem;
            memory_in_use <= usage;
          end
        default: ;
      endcase
    end
  end

  // table bounds, one item in flight, result held under stall
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MaxCount) else $error("pending count beyond table size");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("accepted item while busy");
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    state == mbjd_pkg::S_LPUT |=> count == $past(count) + 1'b1)
    else $error("load did not grow table");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped under stall");
endmodule

// ===== hdl/mbjd_table.sv =====
// Job table: one synchonous memory holding {run time, memory need, index}.
// Depends on mbjd_pkg.
module mbjd_table #(
  parameter int unsigned MAX_JOBS = mbjd_pkg::MaxJobsDefault,
  parameter int unsigned AW = $clog2(MAX_JOBS)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [mbjd_pkg::EntW-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic [mbjd_pkg::EntW-1:0] rdata
);
  logic [mbjd_pkg::EntW-1:0] mem [MAX_JOBS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
